[rtl/move_command_stream_parser_assert.svh]
// Assertion macros for the move command stream parser
`ifndef MOVE_COMMAND_STREAM_PARSER_ASSERT_SVH
`define MOVE_COMMAND_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define MCSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MCSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MCSP_ASSERT_IMPL(label, ante, cons, msg)

`define MCSP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/mcsp_pkg.sv]
// Shared types and constants of the move command stream parser
`timescale 1ns / 1ps

package mcsp_pkg;

  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] STRING_LIMIT_RESET = 16'd260;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_STRING  = 2'd2;

  localparam logic [7:0] ID_INT_FIRST  = 8'd32;
  localparam logic [7:0] ID_INT_SECOND = 8'd33;
  localparam logic [7:0] ID_STR_ONE    = 8'd34;
  localparam logic [7:0] ID_STR_THREE  = 8'd35;

  localparam logic [2:0] PH_ID         = 3'd0;
  localparam logic [2:0] PH_INT_A_ONLY = 3'd1;
  localparam logic [2:0] PH_LEN        = 3'd2;
  localparam logic [2:0] PH_STR        = 3'd3;
  localparam logic [2:0] PH_A          = 3'd4;
  localparam logic [2:0] PH_B          = 3'd5;
  localparam logic [2:0] PH_C          = 3'd6;

  localparam logic [2:0] HEADER_LEN = 3'd4;

  typedef struct packed {
    logic [2:0]  header_position;
    logic [2:0]  parse_phase;
    logic [31:0] integer_accumulator;
    logic [7:0]  current_id;
    logic [31:0] held_a;
    logic [31:0] held_b;
    logic [31:0] held_length;
    logic [31:0] bytes_remaining;
    logic        held_repeat;
    logic        held_skippable;
    logic        held_too_long;
  } parser_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        repeat_flag;
    logic        skippable_flag;
    logic [7:0]  op_id;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [31:0] string_length;
    logic [7:0]  string_byte;
    logic        too_long;
  } result_t;

endpackage

[rtl/mcsp_in_stage.sv]
// Input register of the move command stream parser
`timescale 1ns / 1ps

module mcsp_in_stage
  import mcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_byte,
  input  logic       s_start,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_start
);

  assign s_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      held_byte  <= s_byte;
      held_start <= s_start;
    end
  end

endmodule

[rtl/mcsp_step.sv]
// Per-byte parser step: next parser state and the result of one byte
`timescale 1ns / 1ps

module mcsp_step
  import mcsp_pkg::*;
(
  input  parser_state_t      st,
  input  logic [7:0]         in_byte,
  input  logic               in_start,
  input  logic [LIMIT_W-1:0] string_limit,
  output parser_state_t      st_next,
  output result_t            res,
  output logic               res_valid
);

  parser_state_t s;
  logic [31:0]   acc_shift;
  logic [31:0]   rem_dec;
  logic          int_done;

  assign s         = in_start ? parser_state_t'('0) : st;
  assign acc_shift = {s.integer_accumulator[24:0], in_byte[6:0]};
  assign rem_dec   = s.bytes_remaining - 32'd1;
  assign int_done  = !in_byte[7];

  always_comb begin
    st_next   = s;
    res       = '0;
    res_valid = 1'b0;
    if (s.header_position < HEADER_LEN) begin
      st_next.header_position = s.header_position + 3'd1;
      if (s.header_position == 3'd2) begin
        st_next.held_repeat = (in_byte != 8'd0);
      end
      if (s.header_position == 3'd3) begin
        st_next.held_skippable = (in_byte != 8'd0);
        res.kind               = KIND_HEADER;
        res.repeat_flag        = s.held_repeat;
        res.skippable_flag     = (in_byte != 8'd0);
        res_valid              = 1'b1;
      end
    end else begin
      unique case (s.parse_phase)
        PH_ID: begin
          st_next.current_id          = in_byte;
          st_next.integer_accumulator = '0;
          st_next.held_a              = '0;
          st_next.held_b              = '0;
          st_next.held_length         = '0;
          st_next.held_too_long       = 1'b0;
          st_next.bytes_remaining     = '0;
          if (in_byte == ID_INT_FIRST || in_byte == ID_INT_SECOND) begin
            st_next.parse_phase = PH_INT_A_ONLY;
          end else if (in_byte == ID_STR_ONE || in_byte == ID_STR_THREE) begin
            st_next.parse_phase = PH_LEN;
          end else begin
            res.kind            = KIND_COMMAND;
            res.op_id           = in_byte;
            res_valid           = 1'b1;
            st_next.parse_phase = PH_ID;
          end
        end
        PH_INT_A_ONLY: begin
          st_next.integer_accumulator = int_done ? 32'd0 : acc_shift;
          if (int_done) begin
            res.kind            = KIND_COMMAND;
            res.op_id           = s.current_id;
            res.value_a         = acc_shift;
            res_valid           = 1'b1;
            st_next.parse_phase = PH_ID;
          end
        end
        PH_LEN: begin
          st_next.integer_accumulator = int_done ? 32'd0 : acc_shift;
          if (int_done) begin
            st_next.held_length     = acc_shift;
            st_next.bytes_remaining = acc_shift;
            st_next.held_too_long   = (acc_shift >= {16'd0, string_limit});
            st_next.parse_phase     = (acc_shift == 32'd0) ? PH_A : PH_STR;
          end
        end
        PH_STR: begin
          st_next.bytes_remaining = rem_dec;
          if (rem_dec == 32'd0) begin
            st_next.parse_phase = PH_A;
          end
          if (!s.held_too_long) begin
            res.kind          = KIND_STRING;
            res.op_id         = s.current_id;
            res.string_length = s.held_length;
            res.string_byte   = in_byte;
            res_valid         = 1'b1;
          end
        end
        PH_A: begin
          st_next.integer_accumulator = int_done ? 32'd0 : acc_shift;
          if (int_done) begin
            if (s.current_id == ID_STR_THREE) begin
              st_next.held_a      = acc_shift;
              st_next.parse_phase = PH_B;
            end else begin
              res.kind            = KIND_COMMAND;
              res.op_id           = s.current_id;
              res.value_a         = acc_shift;
              res.string_length   = s.held_length;
              res.too_long        = s.held_too_long;
              res_valid           = 1'b1;
              st_next.parse_phase = PH_ID;
            end
          end
        end
        PH_B: begin
          st_next.integer_accumulator = int_done ? 32'd0 : acc_shift;
          if (int_done) begin
            st_next.held_b      = acc_shift;
            st_next.parse_phase = PH_C;
          end
        end
        PH_C: begin
          st_next.integer_accumulator = int_done ? 32'd0 : acc_shift;
          if (int_done) begin
            res.kind            = KIND_COMMAND;
            res.op_id           = s.current_id;
            res.value_a         = s.held_a;
            res.value_b         = s.held_b;
            res.value_c         = acc_shift;
            res.string_length   = s.held_length;
            res.too_long        = s.held_too_long;
            res_valid           = 1'b1;
            st_next.parse_phase = PH_ID;
          end
        end
        default: begin
          st_next.parse_phase = PH_ID;
        end
      endcase
    end
  end

endmodule

[rtl/mcsp_out_stage.sv]
// Result register of the move command stream parser
`timescale 1ns / 1ps

module mcsp_out_stage
  import mcsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    res_valid,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= res_valid;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      m_res <= res;
    end
  end

endmodule

[rtl/move_command_stream_parser.sv]
// Top level of the move command stream parser
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tdata data_byte, tuser route_start
//   m_axis    out  tvalid/tready           tdata result fields, tuser kind
//   limit     in   string_limit_wr_en      string_limit_wr_data
//
// A transfer moves from the input register through the parser step into the
// result register when it advances; one byte per cycle is sustained while
// m_axis_tready is high. A result is offered on m_axis from the result register.
// A held input byte advances whenever the result register is empty or drained.
// Reset clears parser state, both stage valids and sets string_limit to 260.
`timescale 1ns / 1ps

`include "move_command_stream_parser_assert.svh"

module move_command_stream_parser
  import mcsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tuser,   // [0] route_start
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] repeat_flag, [1] skippable_flag, [9:2] op_id, [41:10] value_a,
  // [73:42] value_b, [105:74] value_c, [137:106] string_length,
  // [145:138] string_byte, [146] too_long, [151:147] zero
  output logic [151:0]       m_axis_tdata,
  output logic [1:0]         m_axis_tuser,   // [1:0] kind
  input  logic               string_limit_wr_en,
  input  logic [LIMIT_W-1:0] string_limit_wr_data
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_start;
  logic               advance;
  logic [LIMIT_W-1:0] string_limit;
  parser_state_t      st;
  parser_state_t      st_next;
  result_t            res;
  logic               res_valid;
  result_t            m_res;

  assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      string_limit <= STRING_LIMIT_RESET;
    end else if (string_limit_wr_en) begin
      string_limit <= string_limit_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  mcsp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_byte     (s_axis_tdata),
    .s_start    (s_axis_tuser),
    .advance    (advance),
    .held_valid (in_valid),
    .held_byte  (in_byte),
    .held_start (in_start)
  );

  mcsp_step u_step (
    .st           (st),
    .in_byte      (in_byte),
    .in_start     (in_start),
    .string_limit (string_limit),
    .st_next      (st_next),
    .res          (res),
    .res_valid    (res_valid)
  );

  mcsp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .res_valid (res_valid),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_res     (m_res)
  );

  assign m_axis_tuser = m_res.kind;
  assign m_axis_tdata = {5'd0, m_res.too_long, m_res.string_byte, m_res.string_length,
                         m_res.value_c, m_res.value_b, m_res.value_a, m_res.op_id,
                         m_res.skippable_flag, m_res.repeat_flag};

  `MCSP_ASSERT_IMPL(a_str_has_bytes, st.parse_phase == PH_STR,
                    st.bytes_remaining != 32'd0, "string phase with no bytes left")
  `MCSP_ASSERT_IMPL(a_kind_legal, m_axis_tvalid, m_axis_tuser <= KIND_STRING,
                    "illegal result kind")
  `MCSP_ASSERT_IMPL(a_str_byte_shown, m_axis_tvalid && m_axis_tuser == KIND_STRING,
                    m_res.string_length != 32'd0 && !m_res.too_long,
                    "string byte from skipped or empty string")
  `MCSP_ASSERT_IMPL(a_header_clean, m_axis_tvalid && m_axis_tuser == KIND_HEADER,
                    m_res.op_id == 8'd0 && m_res.string_length == 32'd0,
                    "header carries command fields")
  `MCSP_ASSERT_IMPL(a_stall_blocks, in_valid && m_axis_tvalid && !m_axis_tready,
                    !s_axis_tready, "input taken while both stages are full")
  `MCSP_ASSERT_NEXT(a_hpos_sat, st.header_position == HEADER_LEN && !(advance && in_start),
                    st.header_position == HEADER_LEN, "header position left saturation")

endmodule
